[rtl/qvr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, constants and payload types for the quaternion vector rotator
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int QW   = 16;           // quaternion component width
    localparam int VW   = 24;           // input component width
    localparam int OW   = 25;           // output component width
    localparam int QPW  = 2 * QW + 1;   // doubled quaternion product width
    localparam int MW   = QPW + 1;      // matrix entry width
    localparam int PW   = MW + VW;      // entry times component width
    localparam int AW   = PW + 1;       // row sum width
    localparam int FRAC = 2 * (QW - 2); // matrix fraction bits
    localparam int SW   = AW - FRAC;    // width after dropping the fraction

    localparam logic signed [MW-1:0] MAT_ONE  = MW'(64'sd1 << FRAC);
    localparam logic signed [AW-1:0] RND_HALF = AW'(64'sd1 << (FRAC - 1));
    localparam logic signed [SW-1:0] OUT_MAX  = SW'((64'sd1 << (OW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] OUT_MIN  = SW'(-(64'sd1 << (OW - 1)));

    localparam logic [QW-1:0] QUAT_W_RESET = QW'(16384);

    typedef enum logic [1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [QW-1:0] w;
        logic [QW-1:0] x;
        logic [QW-1:0] y;
        logic [QW-1:0] z;
    } quat_t;

    // component 0 is x
    typedef struct packed {
        logic [2:0][VW-1:0] c;
    } vec_t;

    // row-major, entry 3*row+col
    typedef struct packed {
        logic [8:0][MW-1:0] m;
    } mat_t;

    typedef struct packed {
        logic [2:0][OW-1:0] rot;
        logic               clipped;
    } res_t;

endpackage

[rtl/qvr_matrix.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_matrix
// Two stages: doubled quaternion products, then rotation matrix entries
// ----------------------------------------------------------------------------
module qvr_matrix (
    input  logic           aclk,
    input  logic           aresetn,
    input  qvr_pkg::quat_t quat,
    input  logic           in_valid,
    output logic           in_ready,
    input  qvr_pkg::vec_t  in_vec,
    output logic           out_valid,
    input  logic           out_ready,
    output qvr_pkg::vec_t  out_vec,
    output qvr_pkg::mat_t  out_mat
);

    logic signed [qvr_pkg::QW-1:0]  qw, qx, qy, qz;
    logic signed [qvr_pkg::QW:0]    x2, y2, z2;
    logic signed [qvr_pkg::QPW-1:0] xx_next, xy_next, xz_next, xw_next, yy_next;
    logic signed [qvr_pkg::QPW-1:0] yz_next, yw_next, zz_next, zw_next;
    logic signed [qvr_pkg::QPW-1:0] xx_reg, xy_reg, xz_reg, xw_reg, yy_reg;
    logic signed [qvr_pkg::QPW-1:0] yz_reg, yw_reg, zz_reg, zw_reg;
    logic signed [qvr_pkg::MW-1:0]  exx, exy, exz, exw, eyy, eyz, eyw, ezz, ezw;
    qvr_pkg::mat_t mat_next, mat_reg;
    qvr_pkg::vec_t vec1_reg, vec2_reg;
    logic          v1_reg, v2_reg;
    logic          en1, en2;

    assign en2       = !v2_reg || out_ready;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign out_vec   = vec2_reg;
    assign out_mat   = mat_reg;

    assign qw = $signed(quat.w);
    assign qx = $signed(quat.x);
    assign qy = $signed(quat.y);
    assign qz = $signed(quat.z);
    assign x2 = {quat.x, 1'b0};
    assign y2 = {quat.y, 1'b0};
    assign z2 = {quat.z, 1'b0};

    always_comb begin
        xx_next = qx * x2;
        xy_next = qx * y2;
        xz_next = qx * z2;
        xw_next = x2 * qw;
        yy_next = qy * y2;
        yz_next = qy * z2;
        yw_next = y2 * qw;
        zz_next = qz * z2;
        zw_next = z2 * qw;
    end

    assign exx = qvr_pkg::MW'(xx_reg);
    assign exy = qvr_pkg::MW'(xy_reg);
    assign exz = qvr_pkg::MW'(xz_reg);
    assign exw = qvr_pkg::MW'(xw_reg);
    assign eyy = qvr_pkg::MW'(yy_reg);
    assign eyz = qvr_pkg::MW'(yz_reg);
    assign eyw = qvr_pkg::MW'(yw_reg);
    assign ezz = qvr_pkg::MW'(zz_reg);
    assign ezw = qvr_pkg::MW'(zw_reg);

    always_comb begin
        mat_next.m[0] = qvr_pkg::MAT_ONE - (eyy + ezz);
        mat_next.m[1] = exy - ezw;
        mat_next.m[2] = exz + eyw;
        mat_next.m[3] = exy + ezw;
        mat_next.m[4] = qvr_pkg::MAT_ONE - (exx + ezz);
        mat_next.m[5] = eyz - exw;
        mat_next.m[6] = exz - eyw;
        mat_next.m[7] = eyz + exw;
        mat_next.m[8] = qvr_pkg::MAT_ONE - (exx + eyy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            xx_reg   <= xx_next;
            xy_reg   <= xy_next;
            xz_reg   <= xz_next;
            xw_reg   <= xw_next;
            yy_reg   <= yy_next;
            yz_reg   <= yz_next;
            yw_reg   <= yw_next;
            zz_reg   <= zz_next;
            zw_reg   <= zw_next;
            vec1_reg <= in_vec;
        end
        if (en2) begin
            mat_reg  <= mat_next;
            vec2_reg <= vec1_reg;
        end
    end

endmodule

[rtl/qvr_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_mac
// Two stages: nine entry-by-component products, then three row sums
// ----------------------------------------------------------------------------
module qvr_mac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  qvr_pkg::vec_t                 in_vec,
    input  qvr_pkg::mat_t                 in_mat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0][qvr_pkg::AW-1:0]   out_acc
);

    logic [8:0][qvr_pkg::PW-1:0] prod_next, prod_reg;
    logic [2:0][qvr_pkg::AW-1:0] acc_next, acc_reg;
    logic                        v1_reg, v2_reg;
    logic                        en1, en2;

    assign en2       = !v2_reg || out_ready;
    assign en1       = !v1_reg || en2;
    assign in_ready  = en1;
    assign out_valid = v2_reg;
    assign out_acc   = acc_reg;

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            prod_next[i] = $signed(in_mat.m[i]) * $signed(in_vec.c[i % 3]);
        end
    end

    // rounding half is folded into the row sum
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            acc_next[r] = qvr_pkg::AW'($signed(prod_reg[3*r]))
                        + qvr_pkg::AW'($signed(prod_reg[3*r+1]))
                        + qvr_pkg::AW'($signed(prod_reg[3*r+2]))
                        + qvr_pkg::RND_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) prod_reg <= prod_next;
        if (en2) acc_reg  <= acc_next;
    end

endmodule

[rtl/qvr_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_round
// Output stage: drop fraction, saturate to the output width, flag clipping
// ----------------------------------------------------------------------------
module qvr_round (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0][qvr_pkg::AW-1:0] in_acc,
    output logic                        out_valid,
    input  logic                        out_ready,
    output qvr_pkg::res_t               out_res
);

    logic signed [qvr_pkg::SW-1:0] sh;
    qvr_pkg::res_t                 res_next, res_reg;
    logic                          v_reg;
    logic                          en;

    assign en        = !v_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg;
    assign out_res   = res_reg;

    always_comb begin
        sh               = '0;
        res_next.clipped = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sh = $signed(in_acc[i][qvr_pkg::AW-1:qvr_pkg::FRAC]);
            if (sh > qvr_pkg::OUT_MAX) begin
                res_next.rot[i]  = qvr_pkg::OUT_MAX[qvr_pkg::OW-1:0];
                res_next.clipped = 1'b1;
            end else if (sh < qvr_pkg::OUT_MIN) begin
                res_next.rot[i]  = qvr_pkg::OUT_MIN[qvr_pkg::OW-1:0];
                res_next.clipped = 1'b1;
            end else begin
                res_next.rot[i]  = sh[qvr_pkg::OW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) res_reg <= res_next;
    end

endmodule

[rtl/quaternion_vector_rotate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates 3-D integer vectors by the quaternion held in four config registers
//
//   channel   direction  handshake             payload
//   s_*       in         s_tvalid / s_tready   vec_x, vec_y, vec_z
//   m_*       out        m_tvalid / m_tready   rot_x, rot_y, rot_z, clipped
//   cfg_*     in         cfg_valid / cfg_ready register index and value
//
// one vector per cycle unless the output stalls; the register stages, in order:
// (products, matrix, multiply, row sum, round and saturate)
// each stage holds its own valid bit and moves when the next one has room,
// so bubbles close up under output stalls; config writes are always taken
// reset clears the valid bits and loads the identity quaternion
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [qvr_pkg::QW-1:0] cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [71:0]            s_tdata,   // vec_x, vec_y, vec_z
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [79:0]            m_tdata,   // rot_x, rot_y, rot_z, zero pad
    output logic [0:0]             m_tuser    // clipped
);

    qvr_pkg::quat_t quat_reg;
    qvr_pkg::vec_t  in_vec;
    qvr_pkg::vec_t  mat_vec;
    qvr_pkg::mat_t  mat;
    qvr_pkg::res_t  res;
    logic [2:0][qvr_pkg::AW-1:0] acc;
    logic           mat_valid, mat_ready;
    logic           acc_valid, acc_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quat_reg.w <= qvr_pkg::QUAT_W_RESET;
            quat_reg.x <= '0;
            quat_reg.y <= '0;
            quat_reg.z <= '0;
        end else if (cfg_valid) begin
            case (qvr_pkg::reg_index_t'(cfg_index))
                qvr_pkg::REG_QUAT_W: quat_reg.w <= cfg_data;
                qvr_pkg::REG_QUAT_X: quat_reg.x <= cfg_data;
                qvr_pkg::REG_QUAT_Y: quat_reg.y <= cfg_data;
                qvr_pkg::REG_QUAT_Z: quat_reg.z <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_vec.c = s_tdata;

    qvr_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .quat      (quat_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_vec    (in_vec),
        .out_valid (mat_valid),
        .out_ready (mat_ready),
        .out_vec   (mat_vec),
        .out_mat   (mat)
    );

    qvr_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mat_valid),
        .in_ready  (mat_ready),
        .in_vec    (mat_vec),
        .in_mat    (mat),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_acc   (acc)
    );

    qvr_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (acc_valid),
        .in_ready  (acc_ready),
        .in_acc    (acc),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {5'b0, res.rot};
    assign m_tuser = res.clipped;

endmodule
